[hw/rtl/leb_pkg.sv]
package leb_pkg;

    localparam int LINE_DEPTH_DEF = 64;
    localparam int CNT_W          = 6;
    localparam int KEY_W          = 8;

    localparam logic [KEY_W-1:0] KEY_CA       = 8'h01;
    localparam logic [KEY_W-1:0] KEY_CB       = 8'h02;
    localparam logic [KEY_W-1:0] KEY_CD       = 8'h04;
    localparam logic [KEY_W-1:0] KEY_CE       = 8'h05;
    localparam logic [KEY_W-1:0] KEY_CF       = 8'h06;
    localparam logic [KEY_W-1:0] KEY_BS       = 8'h08;
    localparam logic [KEY_W-1:0] KEY_LF       = 8'h0A;
    localparam logic [KEY_W-1:0] KEY_CK       = 8'h0B;
    localparam logic [KEY_W-1:0] KEY_CR       = 8'h0D;
    localparam logic [KEY_W-1:0] KEY_PRINT_LO = 8'h20;
    localparam logic [KEY_W-1:0] KEY_PRINT_HI = 8'h7E;
    localparam logic [KEY_W-1:0] KEY_DEL      = 8'h7F;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_CHK,
        S_INS_WR,
        S_DEL_CHK,
        S_DEL_WR,
        S_NL_RD,
        S_NL_EMIT,
        S_EMIT
    } leb_state_t;

    typedef enum logic [3:0] {
        KC_PRINT,
        KC_BS,
        KC_CD,
        KC_CK,
        KC_CA,
        KC_CE,
        KC_CB,
        KC_CF,
        KC_NL,
        KC_OTHER
    } leb_key_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LEN,
        IDX_CUR,
        IDX_CUR_M1,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_LEN,
        CUR_INC,
        CUR_DEC
    } cur_op_t;

    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_INC,
        LEN_DEC,
        LEN_CUR
    } len_op_t;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_IDX_M1,
        RA_IDX_P1
    } rd_sel_t;

    typedef enum logic {
        WR_KEY_AT_CUR,
        WR_DATA_AT_IDX
    } wr_sel_t;

    typedef struct packed {
        logic    load_key;
        logic    set_quit;
        idx_op_t idx_op;
        cur_op_t cur_op;
        len_op_t len_op;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    emit;
        logic    emit_char;
    } leb_cmd_t;

    typedef struct packed {
        leb_key_t key_class;
        logic     len_zero;
        logic     cur_zero;
        logic     line_full;
        logic     cur_lt_len;
        logic     idx_gt_cur;
        logic     idx_p1_lt_len;
        logic     idx_p1_eq_len;
        logic     out_free;
    } leb_status_t;

endpackage

[hw/rtl/leb_datapath.sv]
module leb_datapath
    import leb_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [KEY_W-1:0] s_key_byte,
    input  leb_cmd_t         cmd,
    output leb_status_t      status,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_line_char,
    output logic             m_char_valid,
    output logic             m_last,
    output logic [CNT_W-1:0] m_cursor_out,
    output logic [CNT_W-1:0] m_length_out,
    output logic             m_line_done,
    output logic             m_quit
);

    localparam int PTR_W = $clog2(LINE_DEPTH);
    localparam logic [PTR_W-1:0] LEN_MAX = PTR_W'(LINE_DEPTH - 1);

    logic [7:0] line_mem [LINE_DEPTH];

    logic [KEY_W-1:0] key_reg, key_next;
    logic             quit_reg, quit_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic [PTR_W-1:0] cursor_reg, cursor_next;
    logic [PTR_W-1:0] length_reg, length_next;
    logic [7:0]       rd_data_reg;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       line_char_reg, line_char_next;
    logic             char_valid_reg, char_valid_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] cursor_out_reg, cursor_out_next;
    logic [CNT_W-1:0] length_out_reg, length_out_next;
    logic             line_done_reg, line_done_next;
    logic             quit_out_reg, quit_out_next;

    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic [PTR_W:0]   idx_p1;
    leb_key_t         key_class;

    always_comb begin
        unique case (key_reg) inside
            [KEY_PRINT_LO:KEY_PRINT_HI]: key_class = KC_PRINT;
            KEY_BS, KEY_DEL:             key_class = KC_BS;
            KEY_CD:                      key_class = KC_CD;
            KEY_CK:                      key_class = KC_CK;
            KEY_CA:                      key_class = KC_CA;
            KEY_CE:                      key_class = KC_CE;
            KEY_CB:                      key_class = KC_CB;
            KEY_CF:                      key_class = KC_CF;
            KEY_CR, KEY_LF:              key_class = KC_NL;
            default:                     key_class = KC_OTHER;
        endcase
    end

    assign idx_p1 = {1'b0, idx_reg} + (PTR_W + 1)'(1);

    always_comb begin
        status.key_class     = key_class;
        status.len_zero      = (length_reg == '0);
        status.cur_zero      = (cursor_reg == '0);
        status.line_full     = (length_reg == LEN_MAX);
        status.cur_lt_len    = (cursor_reg < length_reg);
        status.idx_gt_cur    = (idx_reg > cursor_reg);
        status.idx_p1_lt_len = (idx_p1 < {1'b0, length_reg});
        status.idx_p1_eq_len = (idx_p1 == {1'b0, length_reg});
        status.out_free      = !m_valid_reg || m_ready;
    end

    always_comb begin
        unique case (cmd.rd_sel)
            RA_IDX:    rd_addr = idx_reg;
            RA_IDX_M1: rd_addr = idx_reg - PTR_W'(1);
            RA_IDX_P1: rd_addr = idx_reg + PTR_W'(1);
            default:   rd_addr = idx_reg;
        endcase
        unique case (cmd.wr_sel)
            WR_KEY_AT_CUR: begin
                wr_addr = cursor_reg;
                wr_data = key_reg;
            end
            default: begin
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    always_comb begin
        key_next = cmd.load_key ? s_key_byte : key_reg;

        quit_next = quit_reg;
        if (cmd.load_key) begin
            quit_next = 1'b0;
        end
        if (cmd.set_quit) begin
            quit_next = 1'b1;
        end

        unique case (cmd.idx_op)
            IDX_HOLD:   idx_next = idx_reg;
            IDX_LEN:    idx_next = length_reg;
            IDX_CUR:    idx_next = cursor_reg;
            IDX_CUR_M1: idx_next = cursor_reg - PTR_W'(1);
            IDX_ZERO:   idx_next = '0;
            IDX_INC:    idx_next = idx_reg + PTR_W'(1);
            IDX_DEC:    idx_next = idx_reg - PTR_W'(1);
            default:    idx_next = idx_reg;
        endcase

        unique case (cmd.cur_op)
            CUR_HOLD: cursor_next = cursor_reg;
            CUR_ZERO: cursor_next = '0;
            CUR_LEN:  cursor_next = length_reg;
            CUR_INC:  cursor_next = cursor_reg + PTR_W'(1);
            CUR_DEC:  cursor_next = cursor_reg - PTR_W'(1);
            default:  cursor_next = cursor_reg;
        endcase

        unique case (cmd.len_op)
            LEN_HOLD: length_next = length_reg;
            LEN_INC:  length_next = length_reg + PTR_W'(1);
            LEN_DEC:  length_next = length_reg - PTR_W'(1);
            LEN_CUR:  length_next = cursor_reg;
            default:  length_next = length_reg;
        endcase
    end

    always_comb begin
        m_valid_next    = m_valid_reg;
        line_char_next  = line_char_reg;
        char_valid_next = char_valid_reg;
        last_next       = last_reg;
        cursor_out_next = cursor_out_reg;
        length_out_next = length_out_reg;
        line_done_next  = line_done_reg;
        quit_out_next   = quit_out_reg;
        if (cmd.emit) begin
            m_valid_next    = 1'b1;
            line_char_next  = cmd.emit_char ? rd_data_reg : 8'h00;
            char_valid_next = cmd.emit_char;
            last_next       = cmd.emit_char ? status.idx_p1_eq_len : 1'b1;
            cursor_out_next = CNT_W'(cursor_reg);
            length_out_next = CNT_W'(length_reg);
            line_done_next  = (key_class == KC_NL);
            quit_out_next   = quit_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quit_reg    <= 1'b0;
            idx_reg     <= '0;
            cursor_reg  <= '0;
            length_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            quit_reg    <= quit_next;
            idx_reg     <= idx_next;
            cursor_reg  <= cursor_next;
            length_reg  <= length_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        line_char_reg  <= line_char_next;
        char_valid_reg <= char_valid_next;
        last_reg       <= last_next;
        cursor_out_reg <= cursor_out_next;
        length_out_reg <= length_out_next;
        line_done_reg  <= line_done_next;
        quit_out_reg   <= quit_out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_line_char  = line_char_reg;
    assign m_char_valid = char_valid_reg;
    assign m_last       = last_reg;
    assign m_cursor_out = cursor_out_reg;
    assign m_length_out = length_out_reg;
    assign m_line_done  = line_done_reg;
    assign m_quit       = quit_out_reg;

endmodule

[hw/rtl/leb_ctrl.sv]
module leb_ctrl
    import leb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  leb_status_t status,
    output leb_cmd_t    cmd
);

    leb_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd.load_key  = 1'b0;
        cmd.set_quit  = 1'b0;
        cmd.idx_op    = IDX_HOLD;
        cmd.cur_op    = CUR_HOLD;
        cmd.len_op    = LEN_HOLD;
        cmd.rd_en     = 1'b0;
        cmd.rd_sel    = RA_IDX;
        cmd.wr_en     = 1'b0;
        cmd.wr_sel    = WR_KEY_AT_CUR;
        cmd.emit      = 1'b0;
        cmd.emit_char = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_key = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_EMIT;
                unique case (status.key_class)
                    KC_NL: begin
                        if (!status.len_zero) begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_NL_RD;
                        end
                    end
                    KC_PRINT: begin
                        if (!status.line_full) begin
                            cmd.idx_op = IDX_LEN;
                            state_next = S_INS_CHK;
                        end
                    end
                    KC_BS: begin
                        if (!status.cur_zero) begin
                            cmd.cur_op = CUR_DEC;
                            cmd.idx_op = IDX_CUR_M1;
                            state_next = S_DEL_CHK;
                        end
                    end
                    KC_CD: begin
                        if (status.len_zero) begin
                            cmd.set_quit = 1'b1;
                        end else if (status.cur_lt_len) begin
                            cmd.idx_op = IDX_CUR;
                            state_next = S_DEL_CHK;
                        end
                    end
                    KC_CK: cmd.len_op = LEN_CUR;
                    KC_CA: cmd.cur_op = CUR_ZERO;
                    KC_CE: cmd.cur_op = CUR_LEN;
                    KC_CB: begin
                        if (!status.cur_zero) begin
                            cmd.cur_op = CUR_DEC;
                        end
                    end
                    KC_CF: begin
                        if (status.cur_lt_len) begin
                            cmd.cur_op = CUR_INC;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INS_CHK: begin
                if (status.idx_gt_cur) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX_M1;
                    state_next = S_INS_WR;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_KEY_AT_CUR;
                    cmd.len_op = LEN_INC;
                    cmd.cur_op = CUR_INC;
                    state_next = S_EMIT;
                end
            end
            S_INS_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_DATA_AT_IDX;
                cmd.idx_op = IDX_DEC;
                state_next = S_INS_CHK;
            end
            S_DEL_CHK: begin
                if (status.idx_p1_lt_len) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX_P1;
                    state_next = S_DEL_WR;
                end else begin
                    cmd.len_op = LEN_DEC;
                    state_next = S_EMIT;
                end
            end
            S_DEL_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_DATA_AT_IDX;
                cmd.idx_op = IDX_INC;
                state_next = S_DEL_CHK;
            end
            S_NL_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_IDX;
                state_next = S_NL_EMIT;
            end
            S_NL_EMIT: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_char = 1'b1;
                    if (status.idx_p1_eq_len) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_op = IDX_INC;
                        state_next = S_NL_RD;
                    end
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[hw/rtl/line_edit_buffer.sv]
// Single-line editor with emacs-style keys: each request carries one key byte, and
// the block answers with one result (cursor and length after the edit), or on CR/LF
// with one result per character of a non-empty line, the final one marked last. The
// line holds at most LINE_DEPTH-1 characters in a single-port memory, so timing
// follows from memory traffic: a cursor move or ignored key needs only decode and
// emit, an insert shifts the characters from the cursor on right and a delete those
// after it left; a line emission reads each character out. A new request is
// taken while the previous result still waits in the output register.
module line_edit_buffer
    import leb_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [KEY_W-1:0] s_key_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_line_char,
    output logic             m_char_valid,
    output logic             m_last,
    output logic [CNT_W-1:0] m_cursor_out,
    output logic [CNT_W-1:0] m_length_out,
    output logic             m_line_done,
    output logic             m_quit
);

    leb_cmd_t    cmd;
    leb_status_t status;

    leb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    leb_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_key_byte   (s_key_byte),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_char  (m_line_char),
        .m_char_valid (m_char_valid),
        .m_last       (m_last),
        .m_cursor_out (m_cursor_out),
        .m_length_out (m_length_out),
        .m_line_done  (m_line_done),
        .m_quit       (m_quit)
    );

endmodule

[sim/line_edit_buffer_tb.sv]
module line_edit_buffer_tb
    import leb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN     = LINE_DEPTH_DEF - 1;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [7:0]       ch;
        logic             char_valid;
        logic             last;
        logic [CNT_W-1:0] cursor;
        logic [CNT_W-1:0] length;
        logic             line_done;
        logic             quit;
    } edit_result_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [KEY_W-1:0] s_key_byte;
    logic             m_valid;
    logic             m_ready;
    logic [7:0]       m_line_char;
    logic             m_char_valid;
    logic             m_last;
    logic [CNT_W-1:0] m_cursor_out;
    logic [CNT_W-1:0] m_length_out;
    logic             m_line_done;
    logic             m_quit;

    // Shadow copy of the line, updated as each request is accepted.
    logic [7:0]   line_chars [LINE_DEPTH_DEF];
    int           line_cur;
    int           line_len;
    edit_result_t pending_results [$];

    int  keys_sent;
    int  results_seen;
    int  lines_emitted;
    int  errors;
    int  cycles;
    int  hold_len;
    bit  sender_gaps;
    bit  sink_stalls;

    line_edit_buffer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_byte  (s_key_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_line_char (m_line_char),
        .m_char_valid(m_char_valid),
        .m_last      (m_last),
        .m_cursor_out(m_cursor_out),
        .m_length_out(m_length_out),
        .m_line_done (m_line_done),
        .m_quit      (m_quit)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $realtime,
                     pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void push_result(logic [7:0] ch, logic cv, logic last,
                                        logic done, logic quit);
        edit_result_t r;
        r.ch         = ch;
        r.char_valid = cv;
        r.last       = last;
        r.cursor     = CNT_W'(line_cur);
        r.length     = CNT_W'(line_len);
        r.line_done  = done;
        r.quit       = quit;
        pending_results.push_back(r);
    endfunction

    function automatic void remove_char(int pos);
        for (int i = pos; i + 1 < line_len; i++) begin
            line_chars[i] = line_chars[i + 1];
        end
        line_len--;
    endfunction

    function automatic void apply_key(logic [KEY_W-1:0] k);
        logic quit;
        quit = 1'b0;
        if (k == KEY_CR || k == KEY_LF) begin
            lines_emitted++;
            if (line_len == 0) begin
                push_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
            end else begin
                for (int i = 0; i < line_len; i++) begin
                    push_result(line_chars[i], 1'b1, i == line_len - 1, 1'b1, 1'b0);
                end
            end
            return;
        end
        if (k >= KEY_PRINT_LO && k <= KEY_PRINT_HI) begin
            if (line_len < MAX_LEN) begin
                for (int i = line_len; i > line_cur; i--) begin
                    line_chars[i] = line_chars[i - 1];
                end
                line_chars[line_cur] = k;
                line_len++;
                line_cur++;
            end
        end else begin
            case (k) inside
                KEY_BS, KEY_DEL: begin
                    if (line_cur > 0) begin
                        line_cur--;
                        remove_char(line_cur);
                    end
                end
                KEY_CD: begin
                    if (line_len == 0) begin
                        quit = 1'b1;
                    end else if (line_cur < line_len) begin
                        remove_char(line_cur);
                    end
                end
                KEY_CK: line_len = line_cur;
                KEY_CA: line_cur = 0;
                KEY_CE: line_cur = line_len;
                KEY_CB: begin
                    if (line_cur > 0) line_cur--;
                end
                KEY_CF: begin
                    if (line_cur < line_len) line_cur++;
                end
                default: ;
            endcase
        end
        push_result(8'h00, 1'b0, 1'b1, 1'b0, quit);
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 36) return KEY_W'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI));
        if (r < 44) return KEY_BS;
        if (r < 49) return KEY_DEL;
        if (r < 54) return KEY_CA;
        if (r < 58) return KEY_CE;
        if (r < 66) return KEY_CB;
        if (r < 74) return KEY_CF;
        if (r < 80) return KEY_CD;
        if (r < 86) return KEY_CK;
        if (r < 90) return KEY_CR;
        if (r < 94) return KEY_LF;
        return KEY_W'($urandom_range(0, 255));
    endfunction

    // The valid line is only lowered at the start of a gap, so back-to-back
    // requests keep it high.
    task automatic send_key(input logic [KEY_W-1:0] k);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_key_byte <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_key(k);
        keys_sent++;
    endtask

    initial begin : sink
        int n;
        @(posedge aclk);
        forever begin
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 18);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        edit_result_t got;
        edit_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_line_char, m_char_valid, m_last, m_cursor_out, m_length_out,
                    m_line_done, m_quit};
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result char=%02h cv=%0d last=%0d cur=%0d len=%0d",
                         $realtime, got.ch, got.char_valid, got.last, got.cursor,
                         got.length);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    $display({"%0t: mismatch expected char=%02h cv=%0d last=%0d",
                              " cur=%0d len=%0d done=%0d quit=%0d"},
                             $realtime, want.ch, want.char_valid, want.last, want.cursor,
                             want.length, want.line_done, want.quit);
                    $display({"%0t:          actual   char=%02h cv=%0d last=%0d",
                              " cur=%0d len=%0d done=%0d quit=%0d"},
                             $realtime, got.ch, got.char_valid, got.last, got.cursor,
                             got.length, got.line_done, got.quit);
                end
            end
        end
    end

    task automatic test_directed();
        logic [KEY_W-1:0] seq [] = '{
            KEY_LF, KEY_CD, KEY_BS, KEY_CB, KEY_CF, KEY_CK,
            8'h20, 8'h7E, 8'h61, KEY_CA, 8'h78, KEY_CF, KEY_CD, KEY_CE, KEY_CD,
            KEY_CR, KEY_DEL, KEY_CB, KEY_BS,
            8'h00, 8'h80, 8'hFF, 8'h1F, 8'h09,
            KEY_CA, KEY_CK, KEY_CR
        };
        foreach (seq[i]) send_key(seq[i]);
    endtask

    task automatic test_full_line();
        while (line_len < MAX_LEN) begin
            send_key(KEY_W'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI)));
        end
        send_key(8'h41);
        send_key(KEY_CA);
        send_key(8'h42);
        send_key(KEY_CF);
        send_key(KEY_CF);
        send_key(8'h43);
        send_key(KEY_CR);
        send_key(KEY_CD);
        send_key(8'h44);
        send_key(KEY_LF);
        send_key(KEY_CE);
        send_key(KEY_BS);
        send_key(KEY_CA);
        send_key(KEY_CK);
    endtask

    task automatic test_random_edits(input int count);
        repeat (count) send_key(random_key());
    endtask

    task automatic test_backpressure();
        sender_gaps = 1'b0;
        repeat (12) send_key(KEY_W'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI)));
        hold_len = 300;
        send_key(KEY_CR);
        repeat (15) send_key(random_key());
        send_key(KEY_LF);
        sender_gaps = 1'b1;
    endtask

    task automatic test_no_idle();
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_edits(20);
        send_key(KEY_CR);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_key_byte  = '0;
        m_ready     = 1'b0;
        hold_len    = 0;
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        line_cur    = 0;
        line_len    = 0;
        foreach (line_chars[i]) line_chars[i] = 8'h00;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_line();
        test_random_edits(70);
        test_backpressure();
        test_no_idle();

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);

        $display("Sent %0d key requests, checked %0d results, %0d line emissions.",
                 keys_sent, results_seen, lines_emitted);
        $display("Covered full line, empty-line quit, cursor limits and output back-pressure.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/leb_pkg.sv
hw/rtl/leb_datapath.sv
hw/rtl/leb_ctrl.sv
hw/rtl/line_edit_buffer.sv
sim/line_edit_buffer_tb.sv
